// File: design/rcit_pkg.sv
// Shared types, codes and limits for the reference-counted id table.
package rcit_pkg;

   // Default sizes of the table
   localparam int NUM_SLOTS_DEF  = 64;
   localparam int ID_BITS_DEF    = 16;
   localparam int COUNT_BITS_DEF = 8;

   // Widest values the parameters allow; internal buses are sized to these
   localparam int IDX_MAX_BITS   = 10;
   localparam int ID_MAX_BITS    = 32;
   localparam int COUNT_MAX_BITS = 16;

   // Request opcodes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Response status codes
   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_CLAIM    = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_DROP     = 3'd3;
   localparam logic [2:0] ST_RELEASE  = 3'd4;
   localparam logic [2:0] ST_DELETE   = 3'd5;
   localparam logic [2:0] ST_PUT_FREE = 3'd6;
   localparam logic [2:0] ST_LIMIT    = 3'd7;

   typedef struct packed {
      logic        opcode;
      logic [15:0] object_id;
      logic [5:0]  slot;
      logic        no_links;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot_out;
      logic [15:0] id_out;
      logic [7:0]  count_out;
   } rsp_type;

   // Request as broadcast to every cell during a scan
   typedef struct packed {
      logic                   opcode;
      logic [ID_MAX_BITS-1:0] id;
      logic [5:0]             slot;
      logic                   no_links;
   } probe_type;

   // Partial scan result handed from cell to cell
   typedef struct packed {
      logic                      match;
      logic [IDX_MAX_BITS-1:0]   match_idx;
      logic [COUNT_MAX_BITS-1:0] match_cnt;
      logic [ID_MAX_BITS-1:0]    match_id;
      logic                      free;
      logic [IDX_MAX_BITS-1:0]   free_idx;
   } scan_type;

   // Write command broadcast to the cells at the end of a request
   typedef struct packed {
      logic                      en;
      logic                      set_id;
      logic [IDX_MAX_BITS-1:0]   idx;
      logic [COUNT_MAX_BITS-1:0] cnt;
      logic [ID_MAX_BITS-1:0]    id;
   } upd_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_SCAN,
      CTRL_FINISH
   } ctrl_state_type;

endpackage

// File: design/refcounted_id_table.sv
// Top level of the reference-counted id table: sequencer plus a chain of slot cells.
//
// Requests arrive on req_valid/req_stall/req_data: a get looks an object id up and
// takes a reference (claiming the lowest free slot on a miss), a put drops a
// reference on a named slot. Each request yields exactly one response on
// rsp_valid/rsp_stall/rsp_data carrying status, slot, id and the new count.
// Timing: after a request is accepted, a scan token walks the row of NUM_SLOTS
// cells one cell per cycle, each cell folding its own slot into the partial
// result. The last cell's result is captured, then the response is registered;
// no new request is accepted before then. The slot write happens in the same
// cycle the response is registered. req_stall is high from acceptance until the
// response is registered. A stalled response is held in its output register; a
// new request may be accepted meanwhile, and its result waits for the old one
// to drain. Reset clears all counts (every slot free), the scan chain and both
// channels.
module refcounted_id_table #(
   parameter int NUM_SLOTS  = rcit_pkg::NUM_SLOTS_DEF,
   parameter int ID_BITS    = rcit_pkg::ID_BITS_DEF,
   parameter int COUNT_BITS = rcit_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rcit_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rcit_pkg::rsp_type rsp_data
);
   import rcit_pkg::*;

   probe_type              probe;
   upd_type                upd;
   logic                   launch;
   logic [NUM_SLOTS-1:0]   chain_valid;
   scan_type               chain_scan [NUM_SLOTS];
   logic                   link_valid [NUM_SLOTS];
   scan_type               link_scan  [NUM_SLOTS];

   rcit_ctrl #(
      .ID_BITS    (ID_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .launch     (launch),
      .probe      (probe),
      .last_valid (chain_valid[NUM_SLOTS-1]),
      .last_scan  (chain_scan[NUM_SLOTS-1]),
      .upd        (upd)
   );

   // Feed the head of the chain from the sequencer
   assign link_valid[0] = launch;
   assign link_scan[0]  = '0;

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      if (g > 0) begin : g_link
         assign link_valid[g] = chain_valid[g-1];
         assign link_scan[g]  = chain_scan[g-1];
      end

      rcit_cell #(
         .INDEX      (g),
         .ID_BITS    (ID_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .probe      (probe),
         .upd        (upd),
         .prev_valid (link_valid[g]),
         .prev_scan  (link_scan[g]),
         .scan_valid (chain_valid[g]),
         .scan_out   (chain_scan[g])
      );
   end

   // Only one scan token is ever in flight
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0({chain_valid, launch}))
      else $error("more than one scan token in the cell chain");

   // Table writes never overlap a scan
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      !(upd.en && ((|chain_valid) || launch)))
      else $error("slot write while a scan is in flight");

   // A request is only taken when the chain is empty
   a_accept_when_empty: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !((|chain_valid) || launch))
      else $error("request accepted while a scan is in flight");

endmodule

// File: design/rcit_cell.sv
// One table slot: stored id and count, plus one stage of the scan chain.
module rcit_cell #(
   parameter int INDEX      = 0,
   parameter int ID_BITS    = rcit_pkg::ID_BITS_DEF,
   parameter int COUNT_BITS = rcit_pkg::COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  rcit_pkg::probe_type probe,
   input  rcit_pkg::upd_type   upd,
   input  logic                prev_valid,
   input  rcit_pkg::scan_type  prev_scan,
   output logic                scan_valid,
   output rcit_pkg::scan_type  scan_out
);
   import rcit_pkg::*;

   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  valid_ff, valid_in;
   scan_type              scan_ff, scan_in;
   logic                  sel;
   logic                  in_use;
   logic                  mine;

   // Apply a write aimed at this slot
   always_comb begin
      sel      = upd.en && (upd.idx == IDX_MAX_BITS'(INDEX));
      count_in = sel ? upd.cnt[COUNT_BITS-1:0] : count_ff;
      id_in    = (sel && upd.set_id) ? upd.id[ID_BITS-1:0] : id_ff;
   end

   // Merge this slot into the running scan result
   always_comb begin
      in_use = (count_ff != '0);
      if (probe.opcode == OP_GET) begin
         mine = in_use && (id_ff == probe.id[ID_BITS-1:0]);
      end else begin
         mine = in_use && (32'(probe.slot) == 32'(INDEX));
      end
      scan_in  = prev_scan;
      valid_in = prev_valid;
      if (!prev_scan.match && mine) begin
         scan_in.match     = 1'b1;
         scan_in.match_idx = IDX_MAX_BITS'(INDEX);
         scan_in.match_cnt = COUNT_MAX_BITS'(count_ff);
         scan_in.match_id  = ID_MAX_BITS'(id_ff);
      end
      if (!prev_scan.free && !in_use) begin
         scan_in.free     = 1'b1;
         scan_in.free_idx = IDX_MAX_BITS'(INDEX);
      end
   end

   // Hold slot state and advance the scan stage
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      id_ff   <= id_in;
      scan_ff <= scan_in;
   end

   assign scan_valid = valid_ff;
   assign scan_out   = scan_ff;

endmodule

// File: design/rcit_ctrl.sv
// Request sequencer: launches scans, decides the outcome, writes back, drives responses.
module rcit_ctrl #(
   parameter int ID_BITS    = rcit_pkg::ID_BITS_DEF,
   parameter int COUNT_BITS = rcit_pkg::COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rcit_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rcit_pkg::rsp_type   rsp_data,
   output logic                launch,
   output rcit_pkg::probe_type probe,
   input  logic                last_valid,
   input  rcit_pkg::scan_type  last_scan,
   output rcit_pkg::upd_type   upd
);
   import rcit_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

   ctrl_state_type        state_ff, state_in;
   probe_type             probe_ff, probe_in;
   scan_type              res_ff;
   rsp_type               rsp_ff, rsp_in;
   logic                  launch_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  fire;
   logic [COUNT_BITS-1:0] cnt_n, cnt_inc, cnt_dec;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTRL_IDLE: begin
            if (req_valid) state_in = CTRL_SCAN;
         end
         CTRL_SCAN: begin
            if (last_valid) state_in = CTRL_FINISH;
         end
         CTRL_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = CTRL_IDLE;
         end
         default: state_in = CTRL_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_stall = (state_ff != CTRL_IDLE);
      accept    = req_valid && !req_stall;
      fire      = (state_ff == CTRL_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   // Capture the request, masking the id to the stored width
   always_comb begin
      probe_in          = '0;
      probe_in.opcode   = req_data.opcode;
      probe_in.id       = ID_MAX_BITS'(ID_BITS'(req_data.object_id));
      probe_in.slot     = req_data.slot;
      probe_in.no_links = req_data.no_links;
   end

   // Decide the response and the table write
   always_comb begin
      cnt_n   = res_ff.match_cnt[COUNT_BITS-1:0];
      cnt_inc = cnt_n + COUNT_BITS'(1);
      cnt_dec = cnt_n - COUNT_BITS'(1);
      rsp_in  = '0;
      upd     = '0;
      if (probe_ff.opcode == OP_GET) begin
         rsp_in.id_out = probe_ff.id[15:0];
         if (res_ff.match) begin
            if (cnt_n == COUNT_FULL) begin
               rsp_in.status    = ST_LIMIT;
               rsp_in.count_out = 8'(COUNT_FULL);
            end else begin
               rsp_in.status    = ST_HIT;
               rsp_in.slot_out  = res_ff.match_idx[5:0];
               rsp_in.count_out = 8'(cnt_inc);
               upd.en           = fire;
               upd.idx          = res_ff.match_idx;
               upd.cnt          = COUNT_MAX_BITS'(cnt_inc);
            end
         end else if (res_ff.free) begin
            rsp_in.status    = ST_CLAIM;
            rsp_in.slot_out  = res_ff.free_idx[5:0];
            rsp_in.count_out = 8'd1;
            upd.en           = fire;
            upd.set_id       = 1'b1;
            upd.idx          = res_ff.free_idx;
            upd.cnt          = COUNT_MAX_BITS'(1);
            upd.id           = probe_ff.id;
         end else begin
            rsp_in.status = ST_FULL;
         end
      end else begin
         if (!res_ff.match) begin
            rsp_in.status = ST_PUT_FREE;
         end else begin
            rsp_in.slot_out = res_ff.match_idx[5:0];
            rsp_in.id_out   = res_ff.match_id[15:0];
            upd.en          = fire;
            upd.idx         = res_ff.match_idx;
            upd.cnt         = COUNT_MAX_BITS'(cnt_dec);
            if (cnt_dec == '0) begin
               rsp_in.status = probe_ff.no_links ? ST_DELETE : ST_RELEASE;
            end else begin
               rsp_in.status    = ST_DROP;
               rsp_in.count_out = 8'(cnt_dec);
            end
         end
      end
   end

   // Hold the response until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= accept;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) probe_ff <= probe_in;
      if ((state_ff == CTRL_SCAN) && last_valid) res_ff <= last_scan;
      if (fire) rsp_ff <= rsp_in;
   end

   assign launch    = launch_ff;
   assign probe     = probe_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
